// ===== sv/weo_pkg.sv =====
`timescale 1ns / 1ps

package weo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_W = 48;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    localparam int SPD_NUM_W = 32;
    localparam int SPD_DEN_W = 21;
    localparam logic [16:0] SPD_NUM = 17'd100528;
    localparam logic [4:0] SPD_DEN = 5'd17;
    localparam logic [15:0] SPD_MAX = 16'd32767;

    localparam int DIST_PROD_W = 29;
    localparam int DIST_REM_W = 12;
    localparam logic [12:0] DIST_NUM = 13'd6283;
    localparam logic [11:0] DIST_DEN = 12'd2125;
    localparam logic [11:0] DIST_HALF = 12'd1062;

    localparam logic [15:0] MEAN_RECIP = 16'd52429;
    localparam int MEAN_SHIFT = 18;

    localparam int DIST_NUM_W = DIST_PROD_W + FRAC_BITS;
    localparam int DIV_W0 = (DIST_NUM_W > SPD_NUM_W) ? DIST_NUM_W : SPD_NUM_W;
    localparam int DIV_W = DIV_W0 + (DIV_W0 % 2);
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0] req_type;
        logic [14:0] pulses_left;
        logic [14:0] pulses_right;
        logic dir_left;
        logic dir_right;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
        logic signed [15:0] speed_mean;
        logic [15:0] speed_gap;
        logic signed [31:0] distance_mm;
    } result_t;

endpackage

// ===== sv/wheel_encoder_odometry.sv =====
`timescale 1ns / 1ps

// A sample is accepted while idle and passes through the load, divide, saturate, mean,
// multiply and final states, with 16 fraction bits in the radix-4 serial dividers.
// One sample is processed at a time; a new one waits until the final state registers the result.
// Start, stop and unused requests are taken while idle and give no result.
// The asynchronous active-low reset clears the mean, the distance and its enable, and
// sets the interval to 10 ms.
module wheel_encoder_odometry (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  weo_pkg::sample_t    sample,
    output logic                result_valid,
    input  logic                result_stall,
    output weo_pkg::result_t    result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_SAT  = 7'b0001000,
        S_MEAN = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    localparam int DW = weo_pkg::DIV_W;
    localparam int AW = weo_pkg::ACC_W;
    localparam int SRW = weo_pkg::SPD_DEN_W;
    localparam int DRW = weo_pkg::DIST_REM_W;
    localparam int SW = weo_pkg::STEP_W;
    localparam logic [AW-1:0] FRAC_MASK =
        AW'((64'd1 << weo_pkg::FRAC_BITS) - 64'd1);

    state_t state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic res_valid_reg, res_valid_next;
    logic [15:0] interval_reg, interval_next;
    logic [15:0] mean_reg, mean_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic dist_on_reg, dist_on_next;

    logic [14:0] mag_l_reg, mag_l_next;
    logic [14:0] mag_r_reg, mag_r_next;
    logic neg_l_reg, neg_l_next;
    logic neg_r_reg, neg_r_next;
    logic [16:0] sum_reg, sum_next;
    logic [SRW-1:0] den_reg, den_next;
    logic [SRW-1:0] spd_rem_reg [2];
    logic [SRW-1:0] spd_rem_next [2];
    logic [DW-1:0] spd_dq_reg [2];
    logic [DW-1:0] spd_dq_next [2];
    logic [DRW-1:0] dist_rem_reg, dist_rem_next;
    logic [DW-1:0] dist_dq_reg, dist_dq_next;
    logic [15:0] sl_reg, sl_next;
    logic [15:0] sr_reg, sr_next;
    logic [15:0] gap_reg, gap_next;
    logic x_neg_reg, x_neg_next;
    logic [17:0] x_mag_reg, x_mag_next;
    logic [33:0] prod_reg, prod_next;
    weo_pkg::result_t res_reg, res_next;

    logic [SRW-1:0] spd_rem_step [2];
    logic [DW-1:0] spd_dq_step [2];
    logic [DRW-1:0] dist_rem_step;
    logic [DW-1:0] dist_dq_step;

    logic [SRW:0] spd_trial;
    logic [DRW:0] dist_trial;
    logic [SRW-1:0] rem_s;
    logic [DW-1:0] dq_s;
    logic [DRW-1:0] rem_d;
    logic [DW-1:0] dq_d;

    logic [16:0] cl17, cr17;
    logic [15:0] ms;
    logic [15:0] dist_mag;
    logic [DW-1:0] dist_prod;
    logic [31:0] num_l, num_r;
    logic [AW-1:0] inc;
    logic [AW:0] acc_sum;
    logic [16:0] pair_sum, pair_adj, pair_diff;
    logic [15:0] half;
    logic [18:0] x19;
    logic [15:0] mean_q;
    logic [AW-1:0] acc_adj, acc_shift;
    logic [AW-32:0] acc_hi;
    logic [31:0] mm;

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result = res_reg;
    assign cfg_ready = 1'b1;

    // Two quotient bits per cycle for each of the three restoring dividers.
    always_comb
    begin
        for (int w = 0; w < 2; w++)
        begin
            rem_s = spd_rem_reg[w];
            dq_s = spd_dq_reg[w];
            for (int b = 0; b < 2; b++)
            begin
                spd_trial = {rem_s, dq_s[DW-1]};
                dq_s = {dq_s[DW-2:0], 1'b0};
                if (spd_trial >= {1'b0, den_reg})
                begin
                    rem_s = SRW'(spd_trial - {1'b0, den_reg});
                    dq_s[0] = 1'b1;
                end
                else
                begin
                    rem_s = spd_trial[SRW-1:0];
                end
            end
            spd_rem_step[w] = rem_s;
            spd_dq_step[w] = dq_s;
        end
        rem_d = dist_rem_reg;
        dq_d = dist_dq_reg;
        for (int b = 0; b < 2; b++)
        begin
            dist_trial = {rem_d, dq_d[DW-1]};
            dq_d = {dq_d[DW-2:0], 1'b0};
            if (dist_trial >= {1'b0, weo_pkg::DIST_DEN})
            begin
                rem_d = DRW'(dist_trial - {1'b0, weo_pkg::DIST_DEN});
                dq_d[0] = 1'b1;
            end
            else
            begin
                rem_d = dist_trial[DRW-1:0];
            end
        end
        dist_rem_step = rem_d;
        dist_dq_step = dq_d;
    end

    always_comb
    begin
        cl17 = sample.dir_left ? 17'd0 - {2'b00, sample.pulses_left}
                               : {2'b00, sample.pulses_left};
        cr17 = sample.dir_right ? {2'b00, sample.pulses_right}
                                : 17'd0 - {2'b00, sample.pulses_right};

        ms = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
        dist_mag = sum_reg[16] ? 16'(17'd0 - sum_reg) : sum_reg[15:0];
        dist_prod = DW'(29'(dist_mag) * 29'(weo_pkg::DIST_NUM));
        num_l = 32'(mag_l_reg) * 32'(weo_pkg::SPD_NUM);
        num_r = 32'(mag_r_reg) * 32'(weo_pkg::SPD_NUM);

        inc = sum_reg[16] ? AW'(0) - AW'(dist_dq_reg) : AW'(dist_dq_reg);
        acc_sum = {acc_reg[AW-1], acc_reg} + {inc[AW-1], inc};

        pair_sum = {sl_reg[15], sl_reg} + {sr_reg[15], sr_reg};
        pair_adj = pair_sum + {16'd0, pair_sum[16]};
        half = pair_adj[16:1];
        x19 = {mean_reg[15], mean_reg, 2'b00} + {{3{half[15]}}, half};
        pair_diff = {sl_reg[15], sl_reg} - {sr_reg[15], sr_reg};

        mean_q = prod_reg[weo_pkg::MEAN_SHIFT +: 16];
        acc_adj = acc_reg + (acc_reg[AW-1] ? FRAC_MASK : AW'(0));
        acc_shift = AW'($signed(acc_adj) >>> weo_pkg::FRAC_BITS);
        acc_hi = acc_shift[AW-1:31];
        if ((&acc_hi) || !(|acc_hi))
        begin
            mm = acc_shift[31:0];
        end
        else
        begin
            mm = acc_shift[AW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        res_valid_next = res_valid_reg;
        interval_next = interval_reg;
        mean_next = mean_reg;
        acc_next = acc_reg;
        dist_on_next = dist_on_reg;
        mag_l_next = mag_l_reg;
        mag_r_next = mag_r_reg;
        neg_l_next = neg_l_reg;
        neg_r_next = neg_r_reg;
        sum_next = sum_reg;
        den_next = den_reg;
        spd_rem_next = spd_rem_reg;
        spd_dq_next = spd_dq_reg;
        dist_rem_next = dist_rem_reg;
        dist_dq_next = dist_dq_reg;
        sl_next = sl_reg;
        sr_next = sr_reg;
        gap_next = gap_reg;
        x_neg_next = x_neg_reg;
        x_mag_next = x_mag_reg;
        prod_next = prod_reg;
        res_next = res_reg;

        if (cfg_valid)
        begin
            interval_next = cfg_data;
        end
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    case (sample.req_type)
                        weo_pkg::REQ_SAMPLE:
                        begin
                            mag_l_next = sample.pulses_left;
                            mag_r_next = sample.pulses_right;
                            neg_l_next = sample.dir_left;
                            neg_r_next = !sample.dir_right;
                            sum_next = cl17 + cr17;
                            state_next = S_LOAD;
                        end
                        weo_pkg::REQ_START:
                        begin
                            acc_next = '0;
                            dist_on_next = 1'b1;
                        end
                        weo_pkg::REQ_STOP:
                        begin
                            dist_on_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                den_next = SRW'(SRW'(ms) * SRW'(weo_pkg::SPD_DEN));
                spd_rem_next[0] = '0;
                spd_rem_next[1] = '0;
                spd_dq_next[0] = DW'(num_l);
                spd_dq_next[1] = DW'(num_r);
                dist_rem_next = '0;
                dist_dq_next = (dist_prod << weo_pkg::FRAC_BITS) + DW'(weo_pkg::DIST_HALF);
                step_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                spd_rem_next = spd_rem_step;
                spd_dq_next = spd_dq_step;
                dist_rem_next = dist_rem_step;
                dist_dq_next = dist_dq_step;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(weo_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (neg_l_reg)
                begin
                    sl_next = (spd_dq_reg[0] > DW'(weo_pkg::SPD_MAX)) ? 16'h8000
                                : 16'd0 - spd_dq_reg[0][15:0];
                end
                else
                begin
                    sl_next = (spd_dq_reg[0] > DW'(weo_pkg::SPD_MAX)) ? weo_pkg::SPD_MAX
                                : spd_dq_reg[0][15:0];
                end
                if (neg_r_reg)
                begin
                    sr_next = (spd_dq_reg[1] > DW'(weo_pkg::SPD_MAX)) ? 16'h8000
                                : 16'd0 - spd_dq_reg[1][15:0];
                end
                else
                begin
                    sr_next = (spd_dq_reg[1] > DW'(weo_pkg::SPD_MAX)) ? weo_pkg::SPD_MAX
                                : spd_dq_reg[1][15:0];
                end
                if (dist_on_reg)
                begin
                    if (acc_sum[AW] != acc_sum[AW-1])
                    begin
                        acc_next = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}}
                                               : {1'b0, {(AW-1){1'b1}}};
                    end
                    else
                    begin
                        acc_next = acc_sum[AW-1:0];
                    end
                end
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                x_neg_next = x19[18];
                x_mag_next = x19[18] ? 18'(19'd0 - x19) : x19[17:0];
                gap_next = pair_diff[16] ? 16'(17'd0 - pair_diff) : pair_diff[15:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // Division by five as a multiply by the rounded-up reciprocal.
                prod_next = 34'(x_mag_reg) * 34'(weo_pkg::MEAN_RECIP);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    mean_next = x_neg_reg ? 16'd0 - mean_q : mean_q;
                    res_next.speed_left = sl_reg;
                    res_next.speed_right = sr_reg;
                    res_next.speed_mean = x_neg_reg ? 16'd0 - mean_q : mean_q;
                    res_next.speed_gap = gap_reg;
                    res_next.distance_mm = mm;
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            res_valid_reg <= 1'b0;
            interval_reg <= 16'd10;
            mean_reg <= '0;
            acc_reg <= '0;
            dist_on_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            res_valid_reg <= res_valid_next;
            interval_reg <= interval_next;
            mean_reg <= mean_next;
            acc_reg <= acc_next;
            dist_on_reg <= dist_on_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_l_reg <= mag_l_next;
        mag_r_reg <= mag_r_next;
        neg_l_reg <= neg_l_next;
        neg_r_reg <= neg_r_next;
        sum_reg <= sum_next;
        den_reg <= den_next;
        spd_rem_reg <= spd_rem_next;
        spd_dq_reg <= spd_dq_next;
        dist_rem_reg <= dist_rem_next;
        dist_dq_reg <= dist_dq_next;
        sl_reg <= sl_next;
        sr_reg <= sr_next;
        gap_reg <= gap_next;
        x_neg_reg <= x_neg_next;
        x_mag_reg <= x_mag_next;
        prod_reg <= prod_next;
        res_reg <= res_next;
    end

endmodule
